// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define BLVL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BLVL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/blvl_pkg.sv =====
package blvl_pkg;

	localparam int NUM_REGS   = 8;
	localparam int MAX_POINTS = 8;
	localparam int REG_W      = 30;
	localparam int MV_W       = 16;
	localparam int LVL_W      = 14;
	localparam int IDX_W      = $clog2(NUM_REGS);
	localparam int PROD_W     = LVL_W + MV_W;
	localparam int DIV_STEPS  = LVL_W;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);
	localparam int PC_W       = 3;
	localparam int OP_W       = 3;
	localparam int COND_W     = 3;

	localparam int LAST_PT = (MAX_POINTS < 2) ? 1 :
		((MAX_POINTS > NUM_REGS) ? NUM_REGS - 1 : MAX_POINTS - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_PT);

	typedef logic [REG_W-1:0] point_t;

	localparam point_t RESET_CURVE [NUM_REGS] = '{
		30'd655363000, 30'd626330352, 30'd302778820, 30'd58132382,
		30'd1750, 30'd0, 30'd0, 30'd0
	};

	// datapath operations
	localparam logic [OP_W-1:0] OP_IDLE = 3'd0;
	localparam logic [OP_W-1:0] OP_TOP  = 3'd1;
	localparam logic [OP_W-1:0] OP_WALK = 3'd2;
	localparam logic [OP_W-1:0] OP_PREP = 3'd3;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
	localparam logic [OP_W-1:0] OP_DONE = 3'd6;

	// jump conditions
	localparam logic [COND_W-1:0] COND_NEXT   = 3'd0;
	localparam logic [COND_W-1:0] COND_WAIT   = 3'd1;
	localparam logic [COND_W-1:0] COND_GE0    = 3'd2;
	localparam logic [COND_W-1:0] COND_WALK   = 3'd3;
	localparam logic [COND_W-1:0] COND_BELOW  = 3'd4;
	localparam logic [COND_W-1:0] COND_MORE   = 3'd5;
	localparam logic [COND_W-1:0] COND_ALWAYS = 3'd6;

	// program steps
	localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
	localparam logic [PC_W-1:0] PC_TOP  = 3'd1;
	localparam logic [PC_W-1:0] PC_WALK = 3'd2;
	localparam logic [PC_W-1:0] PC_PREP = 3'd3;
	localparam logic [PC_W-1:0] PC_MUL  = 3'd4;
	localparam logic [PC_W-1:0] PC_DIV  = 3'd5;
	localparam logic [PC_W-1:0] PC_DONE = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic wait_in;
		logic ge0;
		logic walk;
		logic below;
		logic more;
	} dp_stat_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w.op = OP_IDLE;
		w.cond = COND_ALWAYS;
		w.target = PC_IDLE;
		case (pc)
			PC_IDLE: begin
				w.op = OP_IDLE; w.cond = COND_WAIT; w.target = PC_IDLE;
			end
			PC_TOP: begin
				w.op = OP_TOP; w.cond = COND_GE0; w.target = PC_IDLE;
			end
			PC_WALK: begin
				w.op = OP_WALK; w.cond = COND_WALK; w.target = PC_WALK;
			end
			PC_PREP: begin
				w.op = OP_PREP; w.cond = COND_BELOW; w.target = PC_IDLE;
			end
			PC_MUL: begin
				w.op = OP_MUL; w.cond = COND_NEXT; w.target = PC_IDLE;
			end
			PC_DIV: begin
				w.op = OP_DIV; w.cond = COND_MORE; w.target = PC_DIV;
			end
			PC_DONE: begin
				w.op = OP_DONE; w.cond = COND_ALWAYS; w.target = PC_IDLE;
			end
			default: begin
				w.op = OP_IDLE; w.cond = COND_ALWAYS; w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/blvl_regs.sv =====
module blvl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [blvl_pkg::IDX_W-1:0]    wr_index,
	input  logic [blvl_pkg::REG_W-1:0]    wr_data,
	output blvl_pkg::point_t              pts [blvl_pkg::NUM_REGS]
);
	import blvl_pkg::*;

	point_t pts_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) pts_q[k] <= RESET_CURVE[k];
		end else if (wr_en) begin
			pts_q[wr_index] <= wr_data;
		end
	end

	assign pts = pts_q;

endmodule

// ===== sv/blvl_useq.sv =====
`include "assert_macros.svh"

module blvl_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  blvl_pkg::dp_stat_t   stat,
	output blvl_pkg::uword_t     uw,
	output logic                 busy
);
	import blvl_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            taken;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			COND_NEXT:   taken = 1'b0;
			COND_WAIT:   taken = stat.wait_in;
			COND_GE0:    taken = stat.ge0;
			COND_WALK:   taken = stat.walk;
			COND_BELOW:  taken = stat.below;
			COND_MORE:   taken = stat.more;
			COND_ALWAYS: taken = 1'b1;
			default:     taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= taken ? uw.target : pc_q + 1'b1;
		end
	end

	assign busy = (pc_q != PC_IDLE);

	`BLVL_ASSERT(a_end_step, $fell(busy) |-> ($past(uw.op) == OP_TOP || $past(uw.op) == OP_PREP || $past(uw.op) == OP_DONE), "program left a non-final step for idle")
	`BLVL_ASSERT(a_div_stays, (uw.op == OP_DIV && !stat.more) |=> (uw.op == OP_DONE), "division loop did not end in the output step")

endmodule

// ===== sv/blvl_dp.sv =====
`include "assert_macros.svh"

module blvl_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [blvl_pkg::MV_W-1:0]     battery_mv,
	input  blvl_pkg::point_t              pts [blvl_pkg::NUM_REGS],
	input  blvl_pkg::uword_t              uw,
	output blvl_pkg::dp_stat_t            stat,
	output logic                          done,
	output logic [blvl_pkg::LVL_W-1:0]    level_pptt
);
	import blvl_pkg::*;

	logic [MV_W-1:0]   mv_q;
	logic [IDX_W-1:0]  idx_q;
	logic [MV_W-1:0]   prev_mv_q;
	logic [LVL_W-1:0]  prev_lvl_q;
	logic [LVL_W-1:0]  lo_lvl_q;
	logic [LVL_W-1:0]  diff_q;
	logic              dn_q;
	logic [MV_W-1:0]   span_q;
	logic [MV_W-1:0]   off_q;
	logic [MV_W-1:0]   rem_q;
	logic [LVL_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [LVL_W-1:0]  level_q;

	point_t            cur;
	logic [MV_W-1:0]   cur_mv;
	logic [LVL_W-1:0]  cur_lvl;
	logic [PROD_W-1:0] prod;
	logic [MV_W:0]     trial;
	logic              fits;

	assign cur     = pts[idx_q];
	assign cur_mv  = cur[MV_W-1:0];
	assign cur_lvl = cur[MV_W +: LVL_W];

	assign prod  = PROD_W'(diff_q) * PROD_W'(off_q);
	assign trial = {rem_q, dvd_q[LVL_W-1]};
	assign fits  = (trial >= {1'b0, span_q});

	assign stat.wait_in = !start;
	assign stat.ge0     = (mv_q >= cur_mv);
	assign stat.below   = (mv_q < cur_mv);
	assign stat.walk    = (idx_q < LAST_IDX) && (cur_lvl != '0) && (mv_q < cur_mv);
	assign stat.more    = (cnt_q != CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (uw.op)
				OP_IDLE: begin
					if (start) idx_q <= '0;
				end
				OP_TOP: begin
					if (stat.ge0) done_q <= 1'b1;
				end
				OP_WALK: begin
					if (stat.walk) idx_q <= idx_q + 1'b1;
				end
				OP_PREP: begin
					if (stat.below) done_q <= 1'b1;
				end
				OP_MUL: begin
					cnt_q <= CNT_W'(DIV_STEPS);
				end
				OP_DIV: begin
					cnt_q <= cnt_q - 1'b1;
				end
				OP_DONE: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_IDLE: begin
				if (start) mv_q <= battery_mv;
			end
			OP_TOP: begin
				if (stat.ge0) level_q <= cur_lvl;
			end
			OP_WALK: begin
				// remember the point just passed as the upper bracket
				if (stat.walk) begin
					prev_mv_q  <= cur_mv;
					prev_lvl_q <= cur_lvl;
				end
			end
			OP_PREP: begin
				if (stat.below) begin
					level_q <= cur_lvl;
				end else begin
					lo_lvl_q <= cur_lvl;
					dn_q     <= (cur_lvl > prev_lvl_q);
					diff_q   <= (cur_lvl > prev_lvl_q) ? cur_lvl - prev_lvl_q
						: prev_lvl_q - cur_lvl;
					span_q   <= prev_mv_q - cur_mv;
					off_q    <= mv_q - cur_mv;
				end
			end
			OP_MUL: begin
				// quotient fits in LVL_W bits, so the top bits already sit below the span
				rem_q <= prod[PROD_W-1:LVL_W];
				dvd_q <= prod[LVL_W-1:0];
			end
			OP_DIV: begin
				rem_q <= fits ? MV_W'(trial - {1'b0, span_q}) : trial[MV_W-1:0];
				dvd_q <= {dvd_q[LVL_W-2:0], fits};
			end
			OP_DONE: begin
				level_q <= dn_q ? lo_lvl_q - dvd_q : lo_lvl_q + dvd_q;
			end
			default: begin
			end
		endcase
	end

	assign done       = done_q;
	assign level_pptt = level_q;

	`BLVL_ASSERT(a_rem_below_span, (uw.op == OP_DIV) |-> (rem_q < span_q), "division remainder not below span")
	`BLVL_ASSERT(a_idx_range, (uw.op == OP_PREP) |-> (idx_q <= LAST_IDX && (stat.below || idx_q != '0)), "interpolation without an upper point")

endmodule

// ===== sv/battery_level_interpolator.sv =====
// One item at a time: the next start is taken in the cycle done is high.
// Clamped results come from the top check or the curve walk (one point per cycle); interpolated
// ones then pass through the multiply step and the 14-step restoring divider.
// Reset clears the sequencer and done and loads the alkaline curve into the point registers.
// The receiver cannot stall: done is high for a single cycle; level_pptt holds it until the next done.
`include "assert_macros.svh"

module battery_level_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [blvl_pkg::MV_W-1:0]     battery_mv,
	output logic                          done,
	output logic [blvl_pkg::LVL_W-1:0]    level_pptt,
	input  logic                          wr_en,
	input  logic [blvl_pkg::IDX_W-1:0]    wr_index,
	input  logic [blvl_pkg::REG_W-1:0]    wr_data
);
	import blvl_pkg::*;

	point_t   pts [NUM_REGS];
	uword_t   uw;
	dp_stat_t stat;

	blvl_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pts      (pts)
	);

	blvl_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw),
		.busy   (busy)
	);

	blvl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.battery_mv (battery_mv),
		.pts        (pts),
		.uw         (uw),
		.stat       (stat),
		.done       (done),
		.level_pptt (level_pptt)
	);

	`BLVL_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not start the program")
	`BLVL_ASSERT(a_done_idle, done |-> !busy, "result strobe while still busy")
	`BLVL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> (!done && !busy), "activity during reset")

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import blvl_pkg::*;

	localparam int ITEMS_PER_PHASE = 110;
	localparam int PHASES          = 10;
	localparam int SETTLE_CYCLES   = 40;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic [IDX_W-1:0] {
		POINT_0, POINT_1, POINT_2, POINT_3, POINT_4, POINT_5, POINT_6, POINT_7
	} point_idx_e;

	typedef enum int {
		CURVE_ALKALINE, CURVE_LIPO, CURVE_ZERO, CURVE_FULL, CURVE_RANDOM, CURVE_NOISE
	} curve_kind_e;

	typedef struct packed {
		bit                 wr;
		point_idx_e         idx;
		point_t             data;
		logic [MV_W-1:0]    mv;
		bit                 known;
		logic [LVL_W-1:0]   lvl;
	} step_t;

	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [LVL_W-1:0] lvl;
	} pending_level_t;

	// Directed walk: alkaline reset curve, lithium-polymer curve, then a full
	// eight-point curve with no zero level and rising segments.
	localparam step_t DIRECTED_STEPS [34] = '{
		'{1'b0, POINT_0, '0, 16'd65535, 1'b1, 14'd10000},
		'{1'b0, POINT_0, '0, 16'd3000,  1'b1, 14'd10000},
		'{1'b0, POINT_0, '0, 16'd2999,  1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd2800,  1'b1, 14'd9557},
		'{1'b0, POINT_0, '0, 16'd2650,  1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd1950,  1'b1, 14'd887},
		'{1'b0, POINT_0, '0, 16'd1751,  1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd1750,  1'b1, 14'd0},
		'{1'b0, POINT_0, '0, 16'd1749,  1'b1, 14'd0},
		'{1'b0, POINT_0, '0, 16'd0,     1'b1, 14'd0},
		'{1'b1, POINT_0, {14'd10000, 16'd3950}, 16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_1, {14'd625, 16'd3550},   16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_2, {14'd0, 16'd3100},     16'd0, 1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd3950,  1'b1, 14'd10000},
		'{1'b0, POINT_0, '0, 16'd3949,  1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd3550,  1'b1, 14'd625},
		'{1'b0, POINT_0, '0, 16'd3300,  1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd3099,  1'b1, 14'd0},
		'{1'b1, POINT_0, 30'h3FFF_FFFF,         16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_1, {14'd100, 16'd60000},  16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_2, {14'd5000, 16'd50000}, 16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_3, {14'd3000, 16'd40000}, 16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_4, {14'd1, 16'd30000},    16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_5, {14'd8000, 16'd20000}, 16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_6, {14'd2, 16'd10000},    16'd0, 1'b0, 14'd0},
		'{1'b1, POINT_7, {14'd12345, 16'd1000}, 16'd0, 1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd65535, 1'b1, 14'd16383},
		'{1'b0, POINT_0, '0, 16'd65534, 1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd55000, 1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd25000, 1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd5000,  1'b0, 14'd0},
		'{1'b0, POINT_0, '0, 16'd1000,  1'b1, 14'd12345},
		'{1'b0, POINT_0, '0, 16'd999,   1'b1, 14'd12345},
		'{1'b0, POINT_0, '0, 16'd0,     1'b1, 14'd12345}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [MV_W-1:0]    battery_mv = '0;
	logic               done;
	logic [LVL_W-1:0]   level_pptt;
	logic               wr_en = 1'b0;
	logic [IDX_W-1:0]   wr_index = '0;
	logic [REG_W-1:0]   wr_data = '0;

	point_t         curve [NUM_REGS] = RESET_CURVE;
	pending_level_t expected_levels [$];
	int             mismatches = 0;
	int             cycle_count = 0;

	battery_level_interpolator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.battery_mv (battery_mv),
		.done       (done),
		.level_pptt (level_pptt),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [LVL_W-1:0] point_level(int unsigned k);
		return curve[k][REG_W-1:MV_W];
	endfunction

	function automatic logic [MV_W-1:0] point_mv(int unsigned k);
		return curve[k][MV_W-1:0];
	endfunction

	// Index of the point that closes the curve: first zero level, or the last one.
	function automatic int unsigned curve_end();
		int unsigned e;
		e = 0;
		while (e < LAST_PT && point_level(e) != 0)
			e++;
		return e;
	endfunction

	function automatic logic [LVL_W-1:0] curve_level(logic [MV_W-1:0] mv);
		int unsigned k, hi_lvl, lo_lvl, span, off, q;
		k = 0;
		if (mv >= point_mv(0))
			return point_level(0);
		while (k < LAST_PT && point_level(k) != 0 && mv < point_mv(k))
			k++;
		if (mv < point_mv(k))
			return point_level(k);
		hi_lvl = point_level(k - 1);
		lo_lvl = point_level(k);
		span = point_mv(k - 1) - point_mv(k);
		off = mv - point_mv(k);
		if (span == 0)
			return LVL_W'(lo_lvl);
		// interpolate up from the lower point, or down from it when the level rises toward lower voltage
		if (hi_lvl >= lo_lvl) begin
			q = ((hi_lvl - lo_lvl) * off) / span;
			return LVL_W'(lo_lvl + q);
		end
		q = ((lo_lvl - hi_lvl) * off) / span;
		return LVL_W'(lo_lvl - q);
	endfunction

	function automatic logic [MV_W-1:0] pick_mv();
		int unsigned e, k;
		e = curve_end();
		k = $urandom_range(0, e);
		case ($urandom_range(0, 9))
			0: return MV_W'($urandom);
			1: return $urandom_range(0, 1) ? '1 : '0;
			2: return point_mv(k);
			3: return $urandom_range(0, 1) ? point_mv(k) + 1'b1 : point_mv(k) - 1'b1;
			default: return MV_W'($urandom_range(point_mv(0), point_mv(e)));
		endcase
	endfunction

	// Drop start and hold until every pending level has come back.
	task automatic drain_levels();
		start <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_point(logic [IDX_W-1:0] idx, point_t data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		curve[idx] = data;
		@(posedge clk);
	endtask

	task automatic send_level_request(logic [MV_W-1:0] mv, int unsigned gap, bit known,
		logic [LVL_W-1:0] lvl);
		wr_en <= 1'b0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		battery_mv <= mv;
		do @(posedge clk); while (busy);
		expected_levels.push_back('{mv, known ? lvl : curve_level(mv)});
	endtask

	task automatic load_curve(curve_kind_e kind);
		point_t      next_pts [NUM_REGS];
		int unsigned n, v, k, lv, step;
		n = $urandom_range(2, NUM_REGS);
		v = $urandom_range(0, 7) == 0 ? 65535 : $urandom_range(1000, 65535);
		for (k = 0; k < NUM_REGS; k++) begin
			case (kind)
				CURVE_ALKALINE: next_pts[k] = RESET_CURVE[k];
				CURVE_LIPO: next_pts[k] = '0;
				CURVE_ZERO: next_pts[k] = '0;
				CURVE_FULL: next_pts[k] = '1;
				CURVE_NOISE: next_pts[k] = REG_W'($urandom);
				default: begin
					if (k < n) begin
						lv = $urandom_range(1, 16383);
						if (k == n - 1 && (n < NUM_REGS || $urandom_range(0, 1) != 0))
							lv = 0;
						next_pts[k] = {LVL_W'(lv), MV_W'(v)};
						// mix tight spans with wide ones
						step = $urandom_range(0, $urandom_range(0, 3) == 0 ? 8 : 20000);
						v = (step > v) ? 0 : v - step;
					end else begin
						next_pts[k] = REG_W'($urandom);
					end
				end
			endcase
		end
		if (kind == CURVE_LIPO) begin
			next_pts[0] = {14'd10000, 16'd3950};
			next_pts[1] = {14'd625, 16'd3550};
			next_pts[2] = {14'd0, 16'd3100};
		end
		drain_levels();
		for (k = 0; k < NUM_REGS; k++)
			write_point(IDX_W'(k), next_pts[k]);
	endtask

	always @(posedge clk) begin
		pending_level_t want;
		if (arst_n && done) begin
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("level word %0d arrived with nothing pending", level_pptt);
			end else begin
				want = expected_levels.pop_front();
				if (level_pptt !== want.lvl) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("level_pptt for %0d mV: expected %0d, got %0d",
							want.mv, want.lvl, level_pptt);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		curve_kind_e kind;
		bit          burst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_STEPS[r]) begin
			if (DIRECTED_STEPS[r].wr) begin
				drain_levels();
				write_point(DIRECTED_STEPS[r].idx, DIRECTED_STEPS[r].data);
			end else begin
				send_level_request(DIRECTED_STEPS[r].mv, $urandom_range(0, 7),
					DIRECTED_STEPS[r].known, DIRECTED_STEPS[r].lvl);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: kind = CURVE_ALKALINE;
				1: kind = CURVE_ZERO;
				2: kind = CURVE_FULL;
				3: kind = CURVE_LIPO;
				9: kind = CURVE_NOISE;
				default: kind = CURVE_RANDOM;
			endcase
			load_curve(kind);
			// some phases run back to back with no gaps at all
			burst = $urandom_range(0, 3) == 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_level_request(pick_mv(), burst ? 0 : $urandom_range(0, 7), 1'b0, '0);
		end

		drain_levels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
